// ===== rtl/dtf_pkg.sv =====
package dtf_pkg;

	// Parser phases, shared by the character front end and the top level.
	localparam logic [2:0] PH_SPACE = 3'd0;
	localparam logic [2:0] PH_INT   = 3'd1;
	localparam logic [2:0] PH_SEEK  = 3'd2;
	localparam logic [2:0] PH_FRAC  = 3'd3;
	localparam logic [2:0] PH_DONE  = 3'd4;
	localparam logic [2:0] PH_PCT   = 3'd5;

	localparam logic [7:0] CH_NUL     = 8'd0;
	localparam logic [7:0] CH_TAB     = 8'd9;
	localparam logic [7:0] CH_CR      = 8'd13;
	localparam logic [7:0] CH_SPACE   = 8'd32;
	localparam logic [7:0] CH_PERCENT = 8'd37;
	localparam logic [7:0] CH_POINT   = 8'd46;
	localparam logic [7:0] CH_ZERO    = 8'd48;
	localparam logic [7:0] CH_NINE    = 8'd57;

	localparam int MAX_FRAC_DIGITS_DEF = 6;
	localparam int WHOLE_W = 16;
	localparam int COUNT_W = 3;
	localparam int POW_W   = 24;
	localparam logic [6:0] PCT_DEN = 7'd100;
	localparam logic [WHOLE_W-1:0] WHOLE_SAT = 16'hFFFF;

	function automatic logic [POW_W-1:0] pow_ten(input logic [COUNT_W-1:0] n);
		logic [POW_W-1:0] p;
		case (n)
			3'd0: p = 24'd1;
			3'd1: p = 24'd10;
			3'd2: p = 24'd100;
			3'd3: p = 24'd1000;
			3'd4: p = 24'd10000;
			3'd5: p = 24'd100000;
			3'd6: p = 24'd1000000;
			3'd7: p = 24'd10000000;
			default: p = 24'd1;
		endcase
		return p;
	endfunction

endpackage

// ===== rtl/dtf_parse.sv =====
module dtf_parse #(
	parameter int MAX_FRAC_DIGITS = dtf_pkg::MAX_FRAC_DIGITS_DEF,
	parameter int FRAC_W = 20
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          take,
	input  logic                          last,
	input  logic [7:0]                    char_code,
	output logic [2:0]                    nxt_phase,
	output logic [dtf_pkg::WHOLE_W-1:0]   nxt_whole,
	output logic [FRAC_W-1:0]             nxt_frac,
	output logic [dtf_pkg::COUNT_W-1:0]   nxt_count
);
	import dtf_pkg::*;

	localparam logic [COUNT_W-1:0] CNT_MAX = COUNT_W'(MAX_FRAC_DIGITS);

	logic [2:0]          phase_q;
	logic [WHOLE_W-1:0]  whole_q;
	logic [FRAC_W-1:0]   frac_q;
	logic [COUNT_W-1:0]  count_q;

	logic                is_dig;
	logic                is_space;
	logic [3:0]          digit;
	logic [WHOLE_W+3:0]  whole_wide;
	logic [FRAC_W+3:0]   frac_wide;

	assign is_dig   = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
	assign is_space = (char_code == CH_SPACE) || ((char_code >= CH_TAB) && (char_code <= CH_CR));
	assign digit    = 4'(char_code - CH_ZERO);

	// Times ten by shift and add.
	assign whole_wide = ({4'b0, whole_q} << 3) + ({4'b0, whole_q} << 1) + (WHOLE_W+4)'(digit);
	assign frac_wide  = ({4'b0, frac_q} << 3) + ({4'b0, frac_q} << 1) + (FRAC_W+4)'(digit);

	always_comb begin
		logic used;
		used      = 1'b0;
		nxt_phase = phase_q;
		nxt_whole = whole_q;
		nxt_frac  = frac_q;
		nxt_count = count_q;
		if (char_code == CH_NUL && phase_q != PH_PCT) begin
			nxt_phase = PH_DONE;
		end else begin
			if (nxt_phase == PH_SPACE) begin
				if (is_space) begin
					used = 1'b1;
				end else begin
					nxt_phase = PH_INT;
				end
			end
			if (!used && nxt_phase == PH_INT) begin
				if (is_dig) begin
					nxt_whole = (whole_wide > (WHOLE_W+4)'(WHOLE_SAT)) ?
						WHOLE_SAT : whole_wide[WHOLE_W-1:0];
					used = 1'b1;
				end else if (char_code == CH_PERCENT) begin
					nxt_phase = PH_PCT;
					used = 1'b1;
				end else begin
					nxt_phase = PH_SEEK;
				end
			end
			if (!used && nxt_phase == PH_SEEK) begin
				if (char_code == CH_POINT) begin
					nxt_phase = PH_FRAC;
				end
				used = 1'b1;
			end
			if (!used && nxt_phase == PH_FRAC) begin
				if (!is_dig) begin
					nxt_phase = PH_DONE;
				end else if (count_q < CNT_MAX) begin
					nxt_frac  = frac_wide[FRAC_W-1:0];
					nxt_count = count_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SPACE;
			whole_q <= '0;
			frac_q  <= '0;
			count_q <= '0;
		end else if (take) begin
			if (last) begin
				phase_q <= PH_SPACE;
				whole_q <= '0;
				frac_q  <= '0;
				count_q <= '0;
			end else begin
				phase_q <= nxt_phase;
				whole_q <= nxt_whole;
				frac_q  <= nxt_frac;
				count_q <= nxt_count;
			end
		end
	end

endmodule

// ===== rtl/dtf_div.sv =====
module dtf_div #(
	parameter int NUM_W = 28,
	parameter int DEN_W = 20
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             busy,
	output logic             done,
	output logic [NUM_W-1:0] quo
);

	localparam int CNT_W = $clog2(NUM_W + 1);
	localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(NUM_W - 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W:0]   trial;
	logic             fits;

	// Restoring division, one quotient bit per cycle; the quotient shifts
	// into the numerator register as its bits are consumed.
	assign trial = {rem_q, num_q[NUM_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == LAST_STEP);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == LAST_STEP) begin
					busy_q <= 1'b0;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
			num_q <= {num_q[NUM_W-2:0], fits};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quo  = num_q;

endmodule

// ===== rtl/decimal_text_to_fixed_8_8_top.sv =====
// ASCII decimal text to unsigned 8.8 fixed point. Characters arrive one per
// transaction on the slave side, with s_tlast set on the final character of
// the string; one 16-bit result leaves on the master side for each string.
// Leading whitespace is skipped and a decimal integer run is gathered
// (saturating at 65535). A '%' directly after that run gives
// integer*256/100 truncated to 16 bits; otherwise the high byte is the
// integer modulo 256 and the low byte is the fraction digits after the
// first '.' scaled by 256/10^n, where up to MAX_FRAC_DIGITS digits are kept.
// A NUL character ends the text early. Once the block is idle, every
// character except the final one is taken without a stall. The final
// character starts a shared restoring divider that produces one quotient
// bit per cycle on DIV_W bits (the fraction width plus eight, and never
// less than 24). The block holds s_tready low from the final character
// until the result has been loaded. The result sits in an output
// register; a new string may start while it waits to be taken, but the
// next division result waits in the divider until that register frees up.
module decimal_text_to_fixed_8_8_top #(
	parameter int MAX_FRAC_DIGITS = dtf_pkg::MAX_FRAC_DIGITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_code
	input  logic        s_tlast,   // end-of-text flag
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // [15:0] fixed_value
);
	import dtf_pkg::*;

	// Fraction accumulator holds up to MAX_FRAC_DIGITS decimal digits.
	localparam int FRAC_W = $clog2(10 ** MAX_FRAC_DIGITS);
	// Divisor holds either 100 or 10^n for n up to MAX_FRAC_DIGITS.
	localparam int PW     = $clog2(10 ** MAX_FRAC_DIGITS + 1);
	localparam int DVS_W  = (PW > 7) ? PW : 7;
	// Numerator is the scaled fraction or the scaled 16-bit integer.
	localparam int DIV_W  = (FRAC_W + 8 > WHOLE_W + 8) ? FRAC_W + 8 : WHOLE_W + 8;

	// Sequencer states.
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_HOLD = 2'd2;

	logic [1:0]          state_q;
	logic                accept;
	logic                start_div;

	logic [2:0]          nxt_phase;
	logic [WHOLE_W-1:0]  nxt_whole;
	logic [FRAC_W-1:0]   nxt_frac;
	logic [COUNT_W-1:0]  nxt_count;

	logic [POW_W-1:0]    pow_full;
	logic [DIV_W-1:0]    div_num;
	logic [DVS_W-1:0]    div_den;
	logic                div_busy;
	logic                div_done;
	logic [DIV_W-1:0]    div_quo;

	logic                pct_q;
	logic [7:0]          whole_byte_q;
	logic                out_valid_q;
	logic [15:0]         out_data_q;
	logic                out_free;
	logic                load_out;
	logic [15:0]         result;

	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign start_div = accept && s_tlast;

	dtf_parse #(
		.MAX_FRAC_DIGITS(MAX_FRAC_DIGITS),
		.FRAC_W(FRAC_W)
	) u_parse (
		.clk(clk),
		.arst_n(arst_n),
		.take(accept),
		.last(s_tlast),
		.char_code(s_tdata),
		.nxt_phase(nxt_phase),
		.nxt_whole(nxt_whole),
		.nxt_frac(nxt_frac),
		.nxt_count(nxt_count)
	);

	// A percent string divides integer*256 by 100; otherwise the kept
	// fraction digits times 256 are divided by ten to the digit count. With
	// no fraction digits that is zero over one, giving a zero low byte.
	assign pow_full = pow_ten(nxt_count);

	always_comb begin
		if (nxt_phase == PH_PCT) begin
			div_num = DIV_W'({nxt_whole, 8'h00});
			div_den = DVS_W'(PCT_DEN);
		end else begin
			div_num = DIV_W'({nxt_frac, 8'h00});
			div_den = pow_full[DVS_W-1:0];
		end
	end

	dtf_div #(
		.NUM_W(DIV_W),
		.DEN_W(DVS_W)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(start_div),
		.num(div_num),
		.den(div_den),
		.busy(div_busy),
		.done(div_done),
		.quo(div_quo)
	);

	// The whole byte and the percent flag are kept aside while the divider
	// runs, since the parser clears itself once the final character is in.
	always_ff @(posedge clk) begin
		if (start_div) begin
			pct_q        <= (nxt_phase == PH_PCT);
			whole_byte_q <= nxt_whole[7:0];
		end
	end

	assign result = pct_q ? div_quo[15:0] : {whole_byte_q, div_quo[7:0]};

	assign out_free = !out_valid_q || m_tready;
	assign load_out = ((state_q == ST_DIV && div_done) || state_q == ST_HOLD) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start_div) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= out_free ? ST_IDLE : ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_data_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// No character is taken while the divider is working on a string.
	assert property (@(posedge clk) disable iff (!arst_n) div_busy |-> !s_tready)
		else $error("input ready while divider busy");

	// The final character of a string always closes the input for a while.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tlast) |=> (!s_tready && div_busy))
		else $error("final character did not start the divider");

	// A new result only appears after a division has finished.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> ($past(div_done) || $past(state_q == ST_HOLD)))
		else $error("result appeared without a finished division");

	// The divider reports completion only while the sequencer waits for it.
	assert property (@(posedge clk) disable iff (!arst_n) div_done |-> (state_q == ST_DIV))
		else $error("division finished outside the divide state");

endmodule
